// ===== design/klru_pkg.sv =====
package klru_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LRU_EVICTION = 3'd3;

  // Request type codes as they arrive on the input channel.
  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_LOOKUP  = 3'd2,
    OP_REFRESH = 3'd3,
    OP_FAILURE = 3'd4,
    OP_PING    = 3'd5,
    OP_CLEANUP = 3'd6,
    OP_TICK    = 3'd7
  } klru_op_t;

  // Result status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_REFUSED   = 2'd2;
  localparam logic [1:0] ST_REMOVE    = 2'd3;

  // One classified request as it sits in the queue.
  typedef struct packed {
    klru_op_t     op;
    logic [63:0]  peer_id;
    logic [31:0]  contact_handle;
  } klru_req_t;

  typedef struct packed {
    logic [4:0]  bucket_size;
    logic [7:0]  fail_limit;
    logic [31:0] stale_ticks;
    logic        lru_eviction_on;
  } klru_cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_EXEC,
    BK_PURGE,
    BK_RESP
  } klru_bk_state_t;

endpackage

// ===== design/klru_if.sv =====
// Request channel: valid, ready and the request fields.
interface klru_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [63:0] peer_id;
  logic [31:0] contact_handle;
  modport source (output valid, output req_type, output peer_id, output contact_handle,
                  input ready);
  modport sink   (input valid, input req_type, input peer_id, input contact_handle,
                  output ready);
endinterface

// Result channel: valid, ready and the result fields.
interface klru_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [31:0] handle_out;
  logic [7:0]  fail_count_out;
  logic        ping_pending_out;
  logic [4:0]  occupancy;
  logic [4:0]  purged_count;
  modport source (output valid, output status, output found, output handle_out,
                  output fail_count_out, output ping_pending_out, output occupancy,
                  output purged_count, input ready);
  modport sink   (input valid, input status, input found, input handle_out,
                  input fail_count_out, input ping_pending_out, input occupancy,
                  input purged_count, output ready);
endinterface

// ===== design/kbucket_lru_contact_table.sv =====
// One k-bucket of peer contacts kept in recency order, oldest first.
// in_req carries requests (req_type, peer_id, contact_handle); out_rsp returns
// one result per request, in request order. Both use valid/ready: a request
// moves at a clock edge where valid and ready are both high.
// cfg_we/cfg_index/cfg_wdata write the bucket size, failure limit, timeout
// and eviction enable; write them only while the block is idle.
// A request waits in the queue, is taken up by the idle sequencer, then passes
// a search state and an execute state; its result is then shown in the
// result state. The single back-end sequencer carries out one request at a
// time and takes no new one before the last result is taken. A cleanup adds
// a compaction walk over every held entry before its result.
// Requests are queued two deep, so the input keeps accepting while a result
// waits; when out_rsp.ready stays low the result holds and the queue fills,
// then in_req.ready drops. Reset empties the bucket, zeroes the tick clock
// and loads the default configuration.
module kbucket_lru_contact_table #(
  parameter int MAX_ENTRIES = klru_pkg::MAX_ENTRIES_DEF,
  parameter int TIME_BITS   = klru_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  klru_req_if.sink                      in_req,
  klru_rsp_if.source                    out_rsp,
  input  logic                          cfg_we,
  input  logic [klru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [klru_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  klru_pkg::klru_cfg_t cfg_r;
  logic                q_valid;
  logic                q_pop;
  klru_pkg::klru_req_t q_head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bucket_size     <= 5'd16;
      cfg_r.fail_limit      <= 8'd3;
      cfg_r.stale_ticks     <= 32'd1000;
      cfg_r.lru_eviction_on <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        klru_pkg::CFG_BUCKET_SIZE:  cfg_r.bucket_size     <= cfg_wdata[4:0];
        klru_pkg::CFG_FAIL_LIMIT:   cfg_r.fail_limit      <= cfg_wdata[7:0];
        klru_pkg::CFG_STALE_TICKS:  cfg_r.stale_ticks     <= cfg_wdata[31:0];
        klru_pkg::CFG_LRU_EVICTION: cfg_r.lru_eviction_on <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  klru_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_head  (q_head)
  );

  klru_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .out_rsp (out_rsp)
  );

endmodule

// ===== design/klru_front.sv =====
// Accepts requests, classifies them and holds them in a two-entry queue.
module klru_front (
  input  logic                 clk,
  input  logic                 rst_n,
  klru_req_if.sink             in_req,
  output logic                 q_valid,
  input  logic                 q_pop,
  output klru_pkg::klru_req_t  q_head
);

  klru_pkg::klru_req_t slot_r [2];
  logic                rd_ptr_r, rd_ptr_nxt;
  logic                wr_ptr_r, wr_ptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push;
  klru_pkg::klru_req_t cls;

  // Classify the incoming request.
  always_comb begin
    cls.op             = klru_pkg::klru_op_t'(in_req.req_type);
    cls.peer_id        = in_req.peer_id;
    cls.contact_handle = in_req.contact_handle;
  end

  assign in_req.ready = (cnt_r != 2'd2);
  assign push         = in_req.valid && in_req.ready;
  assign q_valid      = (cnt_r != 2'd0);
  assign q_head       = slot_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== design/klru_back.sv =====
// Holds the contact table and carries out one request at a time.
module klru_back #(
  parameter int MAX_ENTRIES = klru_pkg::MAX_ENTRIES_DEF,
  parameter int TIME_BITS   = klru_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  klru_pkg::klru_cfg_t  cfg,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  klru_pkg::klru_req_t  q_head,
  klru_rsp_if.source           out_rsp
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  // Contact table, one row of cells per slot.
  logic [63:0]          id_r   [MAX_ENTRIES];
  logic [31:0]          hdl_r  [MAX_ENTRIES];
  logic [TIME_BITS-1:0] seen_r [MAX_ENTRIES];
  logic [7:0]           fail_r [MAX_ENTRIES];
  logic                 pend_r [MAX_ENTRIES];

  logic [CNT_W-1:0]     held_r;
  logic [TIME_BITS-1:0] tick_r;

  klru_pkg::klru_bk_state_t state_r, state_nxt;
  klru_pkg::klru_req_t      req_r;

  // Search results.
  logic                   hit_r;
  logic [IDX_W-1:0]       hit_slot_r;
  logic                   any_stale_r;
  logic [IDX_W-1:0]       stale_slot_r;
  logic [MAX_ENTRIES-1:0] stale_r;

  logic                   hit_c, any_stale_c;
  logic [IDX_W-1:0]       hit_slot_c, stale_slot_c;
  logic [MAX_ENTRIES-1:0] stale_c;

  // Cleanup sweep.
  logic [CNT_W-1:0] rd_i_r;
  logic [CNT_W-1:0] wr_k_r;
  logic [4:0]       purged_r;

  // Result register.
  logic [1:0]  status_r;
  logic [31:0] handle_o_r;
  logic [7:0]  fail_o_r;
  logic        pend_o_r;

  logic [CNT_W-1:0] cap;
  logic             full;
  logic             purge_done;

  // Effective bucket size clamped to one..MAX_ENTRIES.
  always_comb begin
    if (cfg.bucket_size == 5'd0) begin
      cap = CNT_W'(1);
    end else if ({{CNT_W{1'b0}}, cfg.bucket_size} > {5'd0, MAX_CNT}) begin
      cap = MAX_CNT;
    end else begin
      cap = CNT_W'(cfg.bucket_size);
    end
  end
  assign full       = (held_r >= cap);
  assign purge_done = (rd_i_r >= held_r);

  // Search over the held slots: first match and first stale entry.
  always_comb begin
    logic [TIME_BITS-1:0] age;
    hit_c        = 1'b0;
    hit_slot_c   = '0;
    any_stale_c  = 1'b0;
    stale_slot_c = '0;
    for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
      age = tick_r - seen_r[j];
      stale_c[j] = (CNT_W'(j) < held_r) &&
                   ((fail_r[j] >= cfg.fail_limit) ||
                    (CMP_W'(age) >= CMP_W'(cfg.stale_ticks)));
      if ((CNT_W'(j) < held_r) && (id_r[j] == req_r.peer_id)) begin
        hit_c      = 1'b1;
        hit_slot_c = IDX_W'(j);
      end
      if (stale_c[j]) begin
        any_stale_c  = 1'b1;
        stale_slot_c = IDX_W'(j);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      klru_pkg::BK_IDLE:   if (q_valid) state_nxt = klru_pkg::BK_SEARCH;
      klru_pkg::BK_SEARCH: state_nxt = klru_pkg::BK_EXEC;
      klru_pkg::BK_EXEC: begin
        state_nxt = (req_r.op == klru_pkg::OP_CLEANUP) ? klru_pkg::BK_PURGE
                                                       : klru_pkg::BK_RESP;
      end
      klru_pkg::BK_PURGE:  if (purge_done) state_nxt = klru_pkg::BK_RESP;
      klru_pkg::BK_RESP:   if (out_rsp.ready) state_nxt = klru_pkg::BK_IDLE;
      default:             state_nxt = klru_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop = (state_r == klru_pkg::BK_IDLE) && q_valid;
    out_rsp.valid = (state_r == klru_pkg::BK_RESP);
  end

  assign out_rsp.status           = status_r;
  assign out_rsp.found            = hit_r;
  assign out_rsp.handle_out       = handle_o_r;
  assign out_rsp.fail_count_out   = fail_o_r;
  assign out_rsp.ping_pending_out = pend_o_r;
  assign out_rsp.occupancy        = 5'(held_r);
  assign out_rsp.purged_count     = purged_r;

  // Plan of the table update for the request being carried out.
  logic             sh_en;
  logic             wr_en;
  logic [CNT_W-1:0] sh_from;
  logic [CNT_W-1:0] sh_to;
  logic [CNT_W-1:0] held_upd;
  logic [1:0]       status_c;
  logic [7:0]       fail_inc;

  always_comb begin
    sh_en    = 1'b0;
    wr_en    = 1'b0;
    sh_from  = CNT_W'(hit_slot_r);
    sh_to    = held_r - CNT_W'(1);
    held_upd = held_r;
    status_c = klru_pkg::ST_DONE;
    fail_inc = (fail_r[hit_slot_r] == 8'hFF) ? 8'hFF : fail_r[hit_slot_r] + 8'd1;
    case (req_r.op)
      klru_pkg::OP_ADD: begin
        if (hit_r) begin
          sh_en = 1'b1;
          wr_en = 1'b1;
        end else if (!full) begin
          wr_en    = 1'b1;
          sh_from  = held_r;
          sh_to    = held_r;
          held_upd = held_r + CNT_W'(1);
        end else if (any_stale_r) begin
          sh_en   = 1'b1;
          wr_en   = 1'b1;
          sh_from = CNT_W'(stale_slot_r);
        end else if (cfg.lru_eviction_on) begin
          sh_en   = 1'b1;
          wr_en   = 1'b1;
          sh_from = '0;
        end else begin
          status_c = klru_pkg::ST_REFUSED;
        end
      end
      klru_pkg::OP_REMOVE: begin
        if (hit_r) begin
          sh_en    = 1'b1;
          held_upd = held_r - CNT_W'(1);
        end else begin
          status_c = klru_pkg::ST_NOT_FOUND;
        end
      end
      klru_pkg::OP_REFRESH: begin
        if (hit_r) begin
          sh_en = 1'b1;
          wr_en = 1'b1;
        end else begin
          status_c = klru_pkg::ST_NOT_FOUND;
        end
      end
      klru_pkg::OP_FAILURE: begin
        if (!hit_r) begin
          status_c = klru_pkg::ST_NOT_FOUND;
        end else if (fail_inc >= cfg.fail_limit) begin
          status_c = klru_pkg::ST_REMOVE;
        end
      end
      klru_pkg::OP_LOOKUP, klru_pkg::OP_PING: begin
        if (!hit_r) status_c = klru_pkg::ST_NOT_FOUND;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= klru_pkg::BK_IDLE;
      held_r  <= '0;
      tick_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == klru_pkg::BK_EXEC) begin
        held_r <= held_upd;
        if (req_r.op == klru_pkg::OP_TICK) tick_r <= tick_r + TIME_BITS'(1);
      end else if ((state_r == klru_pkg::BK_PURGE) && purge_done) begin
        held_r <= wr_k_r;
      end
    end
  end

  // Request capture, search registers and result register.
  always_ff @(posedge clk) begin
    if (q_pop) req_r <= q_head;
    if (state_r == klru_pkg::BK_SEARCH) begin
      hit_r        <= hit_c;
      hit_slot_r   <= hit_slot_c;
      any_stale_r  <= any_stale_c;
      stale_slot_r <= stale_slot_c;
      stale_r      <= stale_c;
    end
    if (state_r == klru_pkg::BK_EXEC) begin
      status_r   <= status_c;
      purged_r   <= '0;
      rd_i_r     <= '0;
      wr_k_r     <= '0;
      handle_o_r <= '0;
      fail_o_r   <= '0;
      pend_o_r   <= 1'b0;
      case (req_r.op)
        klru_pkg::OP_ADD: begin
          if (wr_en) handle_o_r <= req_r.contact_handle;
        end
        klru_pkg::OP_REFRESH: begin
          if (hit_r) handle_o_r <= hdl_r[hit_slot_r];
        end
        klru_pkg::OP_LOOKUP, klru_pkg::OP_FAILURE, klru_pkg::OP_PING: begin
          if (hit_r) begin
            handle_o_r <= hdl_r[hit_slot_r];
            fail_o_r   <= (req_r.op == klru_pkg::OP_FAILURE) ? fail_inc : fail_r[hit_slot_r];
            pend_o_r   <= (req_r.op == klru_pkg::OP_PING) ? 1'b1 : pend_r[hit_slot_r];
          end
        end
        default: begin
        end
      endcase
    end
    // Cleanup walks one slot a cycle, packing the live entries down.
    if ((state_r == klru_pkg::BK_PURGE) && !purge_done) begin
      rd_i_r <= rd_i_r + CNT_W'(1);
      if (stale_r[rd_i_r[IDX_W-1:0]]) begin
        purged_r <= purged_r + 5'd1;
      end else begin
        wr_k_r <= wr_k_r + CNT_W'(1);
      end
    end
  end

  // Table rows: shift toward the oldest slot, write the newest, or update in place.
  always_ff @(posedge clk) begin
    if (state_r == klru_pkg::BK_EXEC) begin
      for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
        if (sh_en && (CNT_W'(j) >= sh_from) && (CNT_W'(j) < sh_to)) begin
          id_r[j]   <= id_r[j + 1];
          hdl_r[j]  <= hdl_r[j + 1];
          seen_r[j] <= seen_r[j + 1];
          fail_r[j] <= fail_r[j + 1];
          pend_r[j] <= pend_r[j + 1];
        end
      end
      for (int j = 0; j < MAX_ENTRIES; j++) begin
        if (wr_en && (CNT_W'(j) == sh_to)) begin
          id_r[j]   <= (req_r.op == klru_pkg::OP_ADD) ? req_r.peer_id : id_r[hit_slot_r];
          hdl_r[j]  <= (req_r.op == klru_pkg::OP_ADD) ? req_r.contact_handle
                                                     : hdl_r[hit_slot_r];
          seen_r[j] <= tick_r;
          fail_r[j] <= 8'd0;
          pend_r[j] <= 1'b0;
        end
      end
      if (hit_r && (req_r.op == klru_pkg::OP_FAILURE)) fail_r[hit_slot_r] <= fail_inc;
      if (hit_r && (req_r.op == klru_pkg::OP_PING))    pend_r[hit_slot_r] <= 1'b1;
    end else if ((state_r == klru_pkg::BK_PURGE) && !purge_done &&
                 !stale_r[rd_i_r[IDX_W-1:0]]) begin
      id_r[wr_k_r[IDX_W-1:0]]   <= id_r[rd_i_r[IDX_W-1:0]];
      hdl_r[wr_k_r[IDX_W-1:0]]  <= hdl_r[rd_i_r[IDX_W-1:0]];
      seen_r[wr_k_r[IDX_W-1:0]] <= seen_r[rd_i_r[IDX_W-1:0]];
      fail_r[wr_k_r[IDX_W-1:0]] <= fail_r[rd_i_r[IDX_W-1:0]];
      pend_r[wr_k_r[IDX_W-1:0]] <= pend_r[rd_i_r[IDX_W-1:0]];
    end
  end

endmodule

// ===== design/klru_checker.sv =====
// Port-level checks on the result channel.
module klru_checker #(
  parameter int MAX_ENTRIES = klru_pkg::MAX_ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_found,
  input logic [31:0] out_handle,
  input logic [7:0]  out_fail,
  input logic [4:0]  out_occupancy
);

  // A stalled result keeps its status.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  // A miss never reports payload.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == klru_pkg::ST_NOT_FOUND) |->
      !out_found && (out_handle == 32'd0) && (out_fail == 8'd0))
    else $error("not-found result carries payload");

  // A refused add concerns a contact that was absent.
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == klru_pkg::ST_REFUSED) |-> !out_found)
    else $error("refused add of a present contact");

  // Occupancy never exceeds the table depth.
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({27'd0, out_occupancy} <= 32'(MAX_ENTRIES)))
    else $error("occupancy beyond table depth");

endmodule

bind kbucket_lru_contact_table klru_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_klru_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .out_status    (out_rsp.status),
  .out_found     (out_rsp.found),
  .out_handle    (out_rsp.handle_out),
  .out_fail      (out_rsp.fail_count_out),
  .out_occupancy (out_rsp.occupancy)
);
